// ===== rtl/core/ialu_pkg.sv =====
// Shared types, opcodes and microcode table of the iterative integer ALU.
package ialu_pkg;

  localparam int OPND_W = 32;
  localparam int VAL_W  = 63;
  localparam int ACC_W  = 64;
  localparam int PC_W   = 5;
  localparam int CNT_W  = 6;

  // Iteration counts of the loop programs
  localparam logic [CNT_W-1:0] ITER_WORD = CNT_W'(32);
  localparam logic [CNT_W-1:0] ITER_SQRT = CNT_W'(16);
  localparam logic [CNT_W-1:0] CNT_NONE  = '0;

  // First trial bit of the square root
  localparam logic [OPND_W-1:0] SQRT_BIT0 = OPND_W'(1) << 30;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_MUL  = 3'd1,
    CMD_DIV  = 3'd2,
    CMD_SUB  = 3'd3,
    CMD_MOD  = 3'd4,
    CMD_SQR  = 3'd5,
    CMD_SQRT = 3'd6,
    CMD_LOG2 = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_ADD,
    UOP_SUB,
    UOP_SQ_INIT,
    UOP_MUL_STEP,
    UOP_DIV_STEP,
    UOP_SQRT_INIT,
    UOP_SQRT_STEP,
    UOP_LOG_INIT,
    UOP_LOG_STEP
  } uop_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_LOOP,
    SEQ_DONE
  } seq_t;

  typedef enum logic {
    OSEL_ACC,
    OSEL_X
  } osel_t;

  typedef struct packed {
    uop_t             uop;
    seq_t             seq;
    logic [PC_W-1:0]  target;
    logic [CNT_W-1:0] cnt_ld;
    osel_t            osel;
  } uword_t;

  // Sequencer to datapath control
  typedef struct packed {
    logic  load;
    logic  reject;
    uop_t  uop;
    osel_t osel;
    logic  done;
  } dp_ctrl_t;

  // Program entry points
  localparam logic [PC_W-1:0] EP_ADD  = PC_W'(0);
  localparam logic [PC_W-1:0] EP_SUB  = PC_W'(2);
  localparam logic [PC_W-1:0] EP_MUL  = PC_W'(4);
  localparam logic [PC_W-1:0] EP_DIV  = PC_W'(7);
  localparam logic [PC_W-1:0] EP_MOD  = PC_W'(10);
  localparam logic [PC_W-1:0] EP_SQR  = PC_W'(13);
  localparam logic [PC_W-1:0] EP_SQRT = PC_W'(16);
  localparam logic [PC_W-1:0] EP_LOG2 = PC_W'(19);
  localparam logic [PC_W-1:0] PC_ONE  = PC_W'(1);
  localparam logic [PC_W-1:0] PC_TWO  = PC_W'(2);

  function automatic uword_t uw(uop_t uop, seq_t seq, logic [PC_W-1:0] target,
                                logic [CNT_W-1:0] cnt_ld, osel_t osel);
    uword_t w;
    w.uop    = uop;
    w.seq    = seq;
    w.target = target;
    w.cnt_ld = cnt_ld;
    w.osel   = osel;
    return w;
  endfunction

  function automatic logic [PC_W-1:0] entry_pc(cmd_t cmd);
    logic [PC_W-1:0] ep;
    case (cmd)
      CMD_ADD:  ep = EP_ADD;
      CMD_MUL:  ep = EP_MUL;
      CMD_DIV:  ep = EP_DIV;
      CMD_SUB:  ep = EP_SUB;
      CMD_MOD:  ep = EP_MOD;
      CMD_SQR:  ep = EP_SQR;
      CMD_SQRT: ep = EP_SQRT;
      default:  ep = EP_LOG2;
    endcase
    return ep;
  endfunction

  // Microcode ROM: loop words jump to themselves until the count runs out
  function automatic uword_t ucode_word(logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      EP_ADD:           w = uw(UOP_ADD, SEQ_NEXT, EP_ADD, CNT_NONE, OSEL_ACC);
      EP_ADD + PC_ONE:  w = uw(UOP_NOP, SEQ_DONE, EP_ADD, CNT_NONE, OSEL_ACC);
      EP_SUB:           w = uw(UOP_SUB, SEQ_NEXT, EP_SUB, CNT_NONE, OSEL_ACC);
      EP_SUB + PC_ONE:  w = uw(UOP_NOP, SEQ_DONE, EP_SUB, CNT_NONE, OSEL_ACC);
      EP_MUL:           w = uw(UOP_NOP, SEQ_NEXT, EP_MUL, ITER_WORD, OSEL_ACC);
      EP_MUL + PC_ONE:  w = uw(UOP_MUL_STEP, SEQ_LOOP, EP_MUL + PC_ONE, CNT_NONE,
                               OSEL_ACC);
      EP_MUL + PC_TWO:  w = uw(UOP_NOP, SEQ_DONE, EP_MUL, CNT_NONE, OSEL_ACC);
      EP_DIV:           w = uw(UOP_NOP, SEQ_NEXT, EP_DIV, ITER_WORD, OSEL_X);
      EP_DIV + PC_ONE:  w = uw(UOP_DIV_STEP, SEQ_LOOP, EP_DIV + PC_ONE, CNT_NONE,
                               OSEL_X);
      EP_DIV + PC_TWO:  w = uw(UOP_NOP, SEQ_DONE, EP_DIV, CNT_NONE, OSEL_X);
      EP_MOD:           w = uw(UOP_NOP, SEQ_NEXT, EP_MOD, ITER_WORD, OSEL_ACC);
      EP_MOD + PC_ONE:  w = uw(UOP_DIV_STEP, SEQ_LOOP, EP_MOD + PC_ONE, CNT_NONE,
                               OSEL_ACC);
      EP_MOD + PC_TWO:  w = uw(UOP_NOP, SEQ_DONE, EP_MOD, CNT_NONE, OSEL_ACC);
      EP_SQR:           w = uw(UOP_SQ_INIT, SEQ_NEXT, EP_SQR, ITER_WORD, OSEL_ACC);
      EP_SQR + PC_ONE:  w = uw(UOP_MUL_STEP, SEQ_LOOP, EP_SQR + PC_ONE, CNT_NONE,
                               OSEL_ACC);
      EP_SQR + PC_TWO:  w = uw(UOP_NOP, SEQ_DONE, EP_SQR, CNT_NONE, OSEL_ACC);
      EP_SQRT:          w = uw(UOP_SQRT_INIT, SEQ_NEXT, EP_SQRT, ITER_SQRT, OSEL_X);
      EP_SQRT + PC_ONE: w = uw(UOP_SQRT_STEP, SEQ_LOOP, EP_SQRT + PC_ONE, CNT_NONE,
                               OSEL_X);
      EP_SQRT + PC_TWO: w = uw(UOP_NOP, SEQ_DONE, EP_SQRT, CNT_NONE, OSEL_X);
      EP_LOG2:          w = uw(UOP_LOG_INIT, SEQ_NEXT, EP_LOG2, ITER_WORD, OSEL_ACC);
      EP_LOG2 + PC_ONE: w = uw(UOP_LOG_STEP, SEQ_LOOP, EP_LOG2 + PC_ONE, CNT_NONE,
                               OSEL_ACC);
      EP_LOG2 + PC_TWO: w = uw(UOP_NOP, SEQ_DONE, EP_LOG2, CNT_NONE, OSEL_ACC);
      default:          w = uw(UOP_NOP, SEQ_DONE, EP_ADD, CNT_NONE, OSEL_ACC);
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/ialu_useq.sv =====
// Microcode sequencer: program counter, loop counter and control ROM.
module ialu_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  ialu_pkg::cmd_t      cmd,
  input  logic                ok,
  output logic                busy,
  output ialu_pkg::dp_ctrl_t  ctrl
);
  import ialu_pkg::*;

  logic             busy_r, busy_nxt;
  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  uword_t           cw;

  // Current control word
  assign cw   = ucode_word(pc_r);
  assign busy = busy_r;

  // Next program counter, loop count and busy flag
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    cnt_nxt  = cnt_r;
    if (busy_r) begin
      if (cw.cnt_ld != CNT_NONE) begin
        cnt_nxt = cw.cnt_ld;
      end else if (cw.seq == SEQ_LOOP) begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      case (cw.seq)
        SEQ_NEXT: pc_nxt = pc_r + PC_ONE;
        SEQ_LOOP: pc_nxt = (cnt_r != CNT_W'(1)) ? cw.target : pc_r + PC_ONE;
        SEQ_DONE: busy_nxt = 1'b0;
        default:  busy_nxt = 1'b0;
      endcase
    end else if (accept && ok) begin
      busy_nxt = 1'b1;
      pc_nxt   = entry_pc(cmd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath controls
  always_comb begin
    ctrl.load   = accept;
    ctrl.reject = accept && !ok;
    ctrl.uop    = busy_r ? cw.uop : UOP_NOP;
    ctrl.osel   = cw.osel;
    ctrl.done   = busy_r && (cw.seq == SEQ_DONE);
  end

endmodule

// ===== rtl/core/ialu_dpath.sv =====
// Datapath: accumulator, two work registers, separate adder terms per micro-op, result register.
module ialu_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ialu_pkg::dp_ctrl_t                   ctrl,
  input  logic [ialu_pkg::OPND_W-1:0]          opnd_a,
  input  logic [ialu_pkg::OPND_W-1:0]          opnd_b,
  output logic                                 res_strobe,
  output logic signed [ialu_pkg::VAL_W-1:0]    res_value,
  output logic                                 res_invalid
);
  import ialu_pkg::*;

  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [OPND_W-1:0] x_r, x_nxt;
  logic [OPND_W-1:0] y_r, y_nxt;
  logic              strobe_r;
  logic [VAL_W-1:0]  value_r;
  logic              invalid_r;

  logic [OPND_W:0]   add_sum, sub_dif, mul_sum, sqrt_t;
  logic [OPND_W:0]   div_sh;
  logic [OPND_W+1:0] div_dif;
  logic              div_q, sqrt_take;
  logic [VAL_W-1:0]  sel_value;

  // Arithmetic terms for each micro-op
  assign add_sum   = {1'b0, x_r} + {1'b0, y_r};
  assign sub_dif   = {1'b0, x_r} - {1'b0, y_r};
  assign mul_sum   = {1'b0, acc_r[ACC_W-1:OPND_W]} + (y_r[0] ? {1'b0, x_r} : '0);
  assign div_sh    = {acc_r[OPND_W-1:0], x_r[OPND_W-1]};
  assign div_dif   = {1'b0, div_sh} - {2'b00, y_r};
  assign div_q     = !div_dif[OPND_W+1];
  assign sqrt_t    = {1'b0, x_r} + {1'b0, y_r};
  assign sqrt_take = {1'b0, acc_r[OPND_W-1:0]} >= sqrt_t;

  // Register updates per micro-op
  always_comb begin
    acc_nxt = acc_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    case (ctrl.uop)
      UOP_NOP: ;
      UOP_ADD: acc_nxt = {{(ACC_W-OPND_W-1){1'b0}}, add_sum};
      UOP_SUB: acc_nxt = {{(ACC_W-OPND_W-1){sub_dif[OPND_W]}}, sub_dif};
      UOP_SQ_INIT: y_nxt = x_r;
      UOP_MUL_STEP: begin
        acc_nxt = {mul_sum, acc_r[OPND_W-1:1]};
        y_nxt   = y_r >> 1;
      end
      UOP_DIV_STEP: begin
        acc_nxt[OPND_W-1:0] = div_q ? div_dif[OPND_W-1:0] : div_sh[OPND_W-1:0];
        x_nxt               = {x_r[OPND_W-2:0], div_q};
      end
      UOP_SQRT_INIT: begin
        acc_nxt = {{(ACC_W-OPND_W){1'b0}}, x_r};
        x_nxt   = '0;
        y_nxt   = SQRT_BIT0;
      end
      UOP_SQRT_STEP: begin
        if (sqrt_take) begin
          acc_nxt[OPND_W-1:0] = acc_r[OPND_W-1:0] - sqrt_t[OPND_W-1:0];
          x_nxt               = (x_r >> 1) + y_r;
        end else begin
          x_nxt = x_r >> 1;
        end
        y_nxt = y_r >> 2;
      end
      UOP_LOG_INIT: begin
        acc_nxt = '0;
        y_nxt   = x_r - OPND_W'(1);
      end
      UOP_LOG_STEP: begin
        acc_nxt = {{(ACC_W-CNT_W){1'b0}},
                   acc_r[CNT_W-1:0] + CNT_W'(y_r != '0)};
        y_nxt   = y_r >> 1;
      end
      default: ;
    endcase
    // operand capture on request
    if (ctrl.load) begin
      acc_nxt = '0;
      x_nxt   = opnd_a;
      y_nxt   = opnd_b;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
  end

  // Result register
  assign sel_value = (ctrl.osel == OSEL_X) ? {{(VAL_W-OPND_W){1'b0}}, x_r}
                                           : acc_r[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctrl.done || ctrl.reject;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.reject) begin
      value_r   <= '0;
      invalid_r <= 1'b1;
    end else if (ctrl.done) begin
      value_r   <= sel_value;
      invalid_r <= 1'b0;
    end
  end

  assign res_strobe  = strobe_r;
  assign res_value   = $signed(value_r);
  assign res_invalid = invalid_r;

endmodule

// ===== rtl/core/iterative_integer_alu.sv =====
// Top level of the microcoded iterative integer ALU.
//
// Usage: drive in_cmd, in_operand_a and in_operand_b and raise start; the
// request is taken at a clock edge where start is high and busy is low.
// Opcodes: add, multiply, divide, subtract, modulus, square, square root,
// ceiling log2. Operands must be positive; a unary op checks operand a only.
// Each request yields one result on out_value/out_invalid, marked by
// out_strobe for a single cycle. The receiver cannot stall the block.
// A request with a bad operand returns value 0, invalid 1 on the next cycle.
// After acceptance each program steps through its microcode words: add and
// subtract run one arithmetic word and a done word; the other ops run a setup
// word, a loop word repeated once per iteration, and a done word.
// busy stays high while a program runs, so one request is in flight at a
// time; the next can be taken in the cycle the result strobes.
// Reset (rst_n low, synchronous) stops any program and drops busy and
// out_strobe; no result is lost to stalls, since none can occur.
module iterative_integer_alu (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [2:0]                         in_cmd,
  input  logic signed [ialu_pkg::OPND_W-1:0] in_operand_a,
  input  logic signed [ialu_pkg::OPND_W-1:0] in_operand_b,
  output logic                               out_strobe,
  output logic signed [ialu_pkg::VAL_W-1:0]  out_value,
  output logic                               out_invalid
);
  import ialu_pkg::*;

  logic     accept, a_ok, b_ok, unary, ok;
  cmd_t     cmd;
  dp_ctrl_t ctrl;

  // Request decode and operand checks
  assign cmd    = cmd_t'(in_cmd);
  assign accept = start && !busy;
  assign a_ok   = (in_operand_a > 0);
  assign b_ok   = (in_operand_b > 0);
  assign unary  = cmd inside {CMD_SQR, CMD_SQRT, CMD_LOG2};
  assign ok     = unary ? a_ok : (a_ok && b_ok);

  ialu_useq u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .cmd    (cmd),
    .ok     (ok),
    .busy   (busy),
    .ctrl   (ctrl)
  );

  ialu_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .opnd_a      ($unsigned(in_operand_a)),
    .opnd_b      ($unsigned(in_operand_b)),
    .res_strobe  (out_strobe),
    .res_value   (out_value),
    .res_invalid (out_invalid)
  );

endmodule
